// ===== rtl/oale_pkg.sv =====
// Shared constants and types for the ordered array list engine.
`default_nettype none
package oale_pkg;

  localparam int CAPACITY     = 32;
  localparam int KEY_BITS     = 64;
  localparam int PAYLOAD_BITS = 32;

  localparam int ADDR_W  = $clog2(CAPACITY);
  localparam int CNT_W   = $clog2(CAPACITY + 1);
  localparam int ENTRY_W = KEY_BITS + PAYLOAD_BITS;

  typedef enum logic [2:0] {
    OP_CLEAR  = 3'd0,
    OP_INSERT = 3'd1,
    OP_DELETE = 3'd2,
    OP_READ   = 3'd3,
    OP_WRITE  = 3'd4,
    OP_FIND   = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_RANGE = 2'd2,
    STAT_NOKEY = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_SHIFT_UP,
    S_SHIFT_DN,
    S_RD_WAIT,
    S_FIND,
    S_FIN
  } state_t;

endpackage
`default_nettype wire

// ===== rtl/oale_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module oale_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/ordered_array_list_engine_core.sv =====
// Ordered array list engine: top level with operation sequencer and entry RAM.
//
// Holds up to CAPACITY entries (key and payload) in order in one RAM with a
// single write port and a single registered read port. One item is worked at
// a time; req_stall is high from acceptance until the result is loaded into
// the output register, which may still wait on rsp_stall while the next item
// runs. Clear, overwrite, no-op and every error go from the start state
// straight to the result; read waits on the registered RAM read; insert
// moves the entries at and above the position up (none on append), delete
// moves those above the position down, and find scans from entry 0 to a
// match or the end of the list. Shifts and scans are bound by the RAM moving
// one entry per cycle. Stored entries need no clearing pass.
`default_nettype none
module ordered_array_list_engine_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        req_valid,
  output logic             req_stall,
  input  wire logic [2:0]  op,
  input  wire logic        at_end,
  input  wire logic [4:0]  position,
  input  wire logic [63:0] entry_key,
  input  wire logic [31:0] entry_payload,
  output logic             rsp_valid,
  input  wire logic        rsp_stall,
  output logic [1:0]       status,
  output logic [4:0]       found_position,
  output logic [63:0]      read_key,
  output logic [31:0]      read_payload,
  output logic [5:0]       entry_count
);

  localparam int AW = oale_pkg::ADDR_W;
  localparam int CW = oale_pkg::CNT_W;
  localparam int KW = oale_pkg::KEY_BITS;
  localparam int PW = oale_pkg::PAYLOAD_BITS;
  localparam int EW = oale_pkg::ENTRY_W;

  oale_pkg::state_t  state, state_next;
  oale_pkg::op_t     op_q;
  logic              at_end_q;
  logic [4:0]        pos_q;
  logic [KW-1:0]     key_q;
  logic [PW-1:0]     pay_q;
  logic [CW-1:0]     count, count_next;
  logic [CW-1:0]     left, left_next;
  logic [AW-1:0]     ptr, ptr_next;
  logic [AW-1:0]     rd_q, rd_q_next;
  logic [AW-1:0]     dst, dst_next;
  logic              pend, pend_next;
  oale_pkg::status_t res_status, res_status_next;
  logic [AW-1:0]     res_fpos, res_fpos_next;
  logic [KW-1:0]     res_key, res_key_next;
  logic [PW-1:0]     res_pay, res_pay_next;
  logic              load;

  logic              ram_we, ram_re;
  logic [AW-1:0]     ram_wa, ram_ra;
  logic [EW-1:0]     ram_wd, ram_rd;
  logic [KW-1:0]     rd_key;
  logic [PW-1:0]     rd_pay;

  logic              pos_lt_cnt, pos_le_cnt;
  logic [CW-1:0]     dst_v;

  oale_ram #(.WIDTH(EW), .DEPTH(oale_pkg::CAPACITY)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_wa),
    .wdata (ram_wd),
    .re    (ram_re),
    .raddr (ram_ra),
    .rdata (ram_rd)
  );

  assign rd_key     = ram_rd[EW-1 -: KW];
  assign rd_pay     = ram_rd[PW-1:0];
  assign pos_lt_cnt = 32'(pos_q) < 32'(count);
  assign pos_le_cnt = 32'(pos_q) <= 32'(count);
  assign dst_v      = at_end_q ? count : CW'(pos_q);
  assign req_stall  = (state != oale_pkg::S_IDLE);

  always_comb begin
    state_next      = state;
    count_next      = count;
    left_next       = left;
    ptr_next        = ptr;
    rd_q_next       = rd_q;
    dst_next        = dst;
    pend_next       = 1'b0;
    res_status_next = res_status;
    res_fpos_next   = res_fpos;
    res_key_next    = res_key;
    res_pay_next    = res_pay;
    load            = 1'b0;
    ram_we          = 1'b0;
    ram_wa          = dst;
    ram_wd          = {key_q, pay_q};
    ram_re          = 1'b0;
    ram_ra          = ptr;
    unique case (state)
      oale_pkg::S_IDLE: begin
        if (req_valid) begin
          state_next = oale_pkg::S_START;
        end
      end
      oale_pkg::S_START: begin
        res_status_next = oale_pkg::STAT_OK;
        res_fpos_next   = '0;
        res_key_next    = '0;
        res_pay_next    = '0;
        state_next      = oale_pkg::S_FIN;
        unique case (op_q)
          oale_pkg::OP_CLEAR: begin
            count_next = '0;
          end
          oale_pkg::OP_INSERT: begin
            if (count == CW'(oale_pkg::CAPACITY)) begin
              res_status_next = oale_pkg::STAT_FULL;
            end else if (!at_end_q && !pos_le_cnt) begin
              res_status_next = oale_pkg::STAT_RANGE;
            end else begin
              dst_next   = AW'(dst_v);
              left_next  = count - dst_v;
              ptr_next   = AW'(count - CW'(1));
              state_next = oale_pkg::S_SHIFT_UP;
            end
          end
          oale_pkg::OP_DELETE: begin
            if (!pos_lt_cnt) begin
              res_status_next = oale_pkg::STAT_RANGE;
            end else begin
              left_next  = count - CW'(1) - CW'(pos_q);
              ptr_next   = AW'(pos_q) + AW'(1);
              state_next = oale_pkg::S_SHIFT_DN;
            end
          end
          oale_pkg::OP_READ: begin
            if (!pos_lt_cnt) begin
              res_status_next = oale_pkg::STAT_RANGE;
            end else begin
              ram_re     = 1'b1;
              ram_ra     = AW'(pos_q);
              state_next = oale_pkg::S_RD_WAIT;
            end
          end
          oale_pkg::OP_WRITE: begin
            if (!pos_lt_cnt) begin
              res_status_next = oale_pkg::STAT_RANGE;
            end else begin
              ram_we = 1'b1;
              ram_wa = AW'(pos_q);
            end
          end
          oale_pkg::OP_FIND: begin
            res_status_next = oale_pkg::STAT_NOKEY;
            left_next       = count;
            ptr_next        = '0;
            state_next      = oale_pkg::S_FIND;
          end
          default: ;
        endcase
      end
      oale_pkg::S_SHIFT_UP: begin
        if (left != '0) begin
          ram_re    = 1'b1;
          ram_ra    = ptr;
          rd_q_next = ptr;
          ptr_next  = ptr - AW'(1);
          left_next = left - CW'(1);
          pend_next = 1'b1;
        end
        if (pend) begin
          ram_we = 1'b1;
          ram_wa = rd_q + AW'(1);
          ram_wd = ram_rd;
        end else if (left == '0) begin
          ram_we     = 1'b1;
          ram_wa     = dst;
          count_next = count + CW'(1);
          state_next = oale_pkg::S_FIN;
        end
      end
      oale_pkg::S_SHIFT_DN: begin
        if (left != '0) begin
          ram_re    = 1'b1;
          ram_ra    = ptr;
          rd_q_next = ptr;
          ptr_next  = ptr + AW'(1);
          left_next = left - CW'(1);
          pend_next = 1'b1;
        end
        if (pend) begin
          ram_we = 1'b1;
          ram_wa = rd_q - AW'(1);
          ram_wd = ram_rd;
        end else if (left == '0) begin
          count_next = count - CW'(1);
          state_next = oale_pkg::S_FIN;
        end
      end
      oale_pkg::S_RD_WAIT: begin
        res_key_next = rd_key;
        res_pay_next = rd_pay;
        state_next   = oale_pkg::S_FIN;
      end
      oale_pkg::S_FIND: begin
        if (pend && rd_key == key_q) begin
          res_status_next = oale_pkg::STAT_OK;
          res_fpos_next   = rd_q;
          res_key_next    = rd_key;
          res_pay_next    = rd_pay;
          state_next      = oale_pkg::S_FIN;
        end else if (left != '0) begin
          ram_re    = 1'b1;
          ram_ra    = ptr;
          rd_q_next = ptr;
          ptr_next  = ptr + AW'(1);
          left_next = left - CW'(1);
          pend_next = 1'b1;
        end else if (!pend) begin
          state_next = oale_pkg::S_FIN;
        end
      end
      oale_pkg::S_FIN: begin
        if (!rsp_valid || !rsp_stall) begin
          load       = 1'b1;
          state_next = oale_pkg::S_IDLE;
        end
      end
      default: state_next = oale_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= oale_pkg::S_IDLE;
      count     <= '0;
      pend      <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      pend  <= pend_next;
      if (load) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && !req_stall) begin
      op_q     <= oale_pkg::op_t'(op);
      at_end_q <= at_end;
      pos_q    <= position;
      key_q    <= KW'(entry_key);
      pay_q    <= PW'(entry_payload);
    end
    left       <= left_next;
    ptr        <= ptr_next;
    rd_q       <= rd_q_next;
    dst        <= dst_next;
    res_status <= res_status_next;
    res_fpos   <= res_fpos_next;
    res_key    <= res_key_next;
    res_pay    <= res_pay_next;
    if (load) begin
      status         <= res_status;
      found_position <= 5'(res_fpos);
      read_key       <= 64'(res_key);
      read_payload   <= 32'(res_pay);
      entry_count    <= 6'(count);
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(oale_pkg::CAPACITY))
    else $error("entry count above capacity");

  a_accept_start: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> state == oale_pkg::S_START)
    else $error("accepted item did not start");

  a_ram_no_collide: assert property (@(posedge clk) disable iff (rst)
    ram_we && ram_re |-> ram_wa != ram_ra)
    else $error("RAM read and write hit the same entry");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status == oale_pkg::STAT_FULL |-> entry_count == 6'(oale_pkg::CAPACITY))
    else $error("full status with list not full");

  a_load_slot_free: assert property (@(posedge clk) disable iff (rst)
    load |-> !rsp_valid || !rsp_stall)
    else $error("result loaded over a waiting item");

endmodule
`default_nettype wire

// ===== verif/ordered_array_list_engine_core_tb.sv =====
// Testbench for the ordered array list engine: directed table, random ops, self-checking.
`timescale 1ns / 1ps
module ordered_array_list_engine_core_tb;

  localparam logic [2:0] OP_SPARE_A = 3'd6;
  localparam logic [2:0] OP_SPARE_B = 3'd7;
  localparam int RAND_ITEMS = 930;
  localparam int PHASE_LEN  = 310;
  localparam int DRAIN_WAIT = 40;
  localparam int STALL_LIMIT = 2000;

  typedef struct {
    oale_pkg::status_t st;
    logic [4:0]  fpos;
    logic [63:0] key;
    logic [31:0] pay;
    logic [5:0]  cnt;
  } list_result_t;

  typedef struct {
    logic [2:0]   op;
    logic         at_end;
    logic [4:0]   pos;
    logic [63:0]  key;
    logic [31:0]  pay;
    bit           typed;
    list_result_t res;
  } list_row_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        req_valid = 1'b0;
  logic        req_stall;
  logic [2:0]  op = oale_pkg::OP_CLEAR;
  logic        at_end = 1'b0;
  logic [4:0]  position = '0;
  logic [63:0] entry_key = '0;
  logic [31:0] entry_payload = '0;
  logic        rsp_valid;
  logic        rsp_stall = 1'b0;
  logic [1:0]  status;
  logic [4:0]  found_position;
  logic [63:0] read_key;
  logic [31:0] read_payload;
  logic [5:0]  entry_count;

  // predicted list contents
  logic [63:0] key_mem [oale_pkg::CAPACITY];
  logic [31:0] pay_mem [oale_pkg::CAPACITY];
  int          list_cnt = 0;

  list_result_t expected_results [$];
  list_result_t head;
  list_row_t    dir_rows [$];

  int snd_idle = 36;
  int rcv_idle = 61;
  int errors = 0;
  int n_items = 0;
  int n_results = 0;
  int n_full = 0;
  int n_range = 0;
  int n_nokey = 0;
  int peak_cnt = 0;
  int quiet_cycles = 0;

  ordered_array_list_engine_core i_dut (.*);

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  function automatic list_result_t list_apply(logic [2:0] o, logic ae, logic [4:0] pos,
                                              logic [63:0] k, logic [31:0] p);
    list_result_t r;
    int dst;
    r = '{st: oale_pkg::STAT_OK, fpos: '0, key: '0, pay: '0, cnt: '0};
    case (o)
      oale_pkg::OP_CLEAR: list_cnt = 0;
      oale_pkg::OP_INSERT: begin
        if (list_cnt >= oale_pkg::CAPACITY) begin
          r.st = oale_pkg::STAT_FULL;
        end else begin
          dst = ae ? list_cnt : int'(pos);
          if (dst > list_cnt) begin
            r.st = oale_pkg::STAT_RANGE;
          end else begin
            for (int i = list_cnt; i > dst; i--) begin
              key_mem[i] = key_mem[i - 1];
              pay_mem[i] = pay_mem[i - 1];
            end
            key_mem[dst] = k;
            pay_mem[dst] = p;
            list_cnt++;
          end
        end
      end
      oale_pkg::OP_DELETE: begin
        if (int'(pos) >= list_cnt) begin
          r.st = oale_pkg::STAT_RANGE;
        end else begin
          for (int i = int'(pos); i + 1 < list_cnt; i++) begin
            key_mem[i] = key_mem[i + 1];
            pay_mem[i] = pay_mem[i + 1];
          end
          list_cnt--;
        end
      end
      oale_pkg::OP_READ: begin
        if (int'(pos) >= list_cnt) begin
          r.st = oale_pkg::STAT_RANGE;
        end else begin
          r.key = key_mem[pos];
          r.pay = pay_mem[pos];
        end
      end
      oale_pkg::OP_WRITE: begin
        if (int'(pos) >= list_cnt) begin
          r.st = oale_pkg::STAT_RANGE;
        end else begin
          key_mem[pos] = k;
          pay_mem[pos] = p;
        end
      end
      oale_pkg::OP_FIND: begin
        r.st = oale_pkg::STAT_NOKEY;
        for (int i = 0; i < list_cnt; i++) begin
          if (key_mem[i] == k) begin
            r.st = oale_pkg::STAT_OK;
            r.fpos = 5'(i);
            r.key = key_mem[i];
            r.pay = pay_mem[i];
            break;
          end
        end
      end
      default: ;
    endcase
    r.cnt = 6'(list_cnt);
    return r;
  endfunction

  task automatic add_row(logic [2:0] o, logic ae, logic [4:0] pos, logic [63:0] k,
                         logic [31:0] p, bit typed,
                         oale_pkg::status_t st = oale_pkg::STAT_OK,
                         logic [4:0] fpos = '0, logic [63:0] rk = '0,
                         logic [31:0] rp = '0, logic [5:0] cnt = '0);
    list_row_t row;
    row.op = o;
    row.at_end = ae;
    row.pos = pos;
    row.key = k;
    row.pay = p;
    row.typed = typed;
    row.res = '{st: st, fpos: fpos, key: rk, pay: rp, cnt: cnt};
    dir_rows.push_back(row);
  endtask

  task automatic send_item(list_row_t row);
    list_result_t r;
    if ($urandom_range(99) < snd_idle) begin
      req_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < snd_idle);
    end
    req_valid     <= 1'b1;
    op            <= row.op;
    at_end        <= row.at_end;
    position      <= row.pos;
    entry_key     <= row.key;
    entry_payload <= row.pay;
    do @(posedge clk); while (req_stall);
    r = list_apply(row.op, row.at_end, row.pos, row.key, row.pay);
    expected_results.push_back(row.typed ? row.res : r);
    n_items++;
  endtask

  task automatic drain_pause();
    req_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  function automatic list_row_t random_row(int n);
    list_row_t row;
    int ins;
    int del;
    int w;
    case ((n / 60) % 3)
      0: begin ins = 55; del = 10; end
      1: begin ins = 12; del = 45; end
      default: begin ins = 30; del = 28; end
    endcase
    w = $urandom_range(99);
    if ($urandom_range(199) == 0) row.op = oale_pkg::OP_CLEAR;
    else if (w < 2) row.op = (w % 2 == 0) ? OP_SPARE_A : OP_SPARE_B;
    else if (w < 2 + ins) row.op = oale_pkg::OP_INSERT;
    else if (w < 2 + ins + del) row.op = oale_pkg::OP_DELETE;
    else begin
      case (w % 3)
        0: row.op = oale_pkg::OP_READ;
        1: row.op = oale_pkg::OP_WRITE;
        default: row.op = oale_pkg::OP_FIND;
      endcase
    end
    row.at_end = ($urandom_range(99) < 30);
    row.pos = 5'($urandom_range(31));
    if ($urandom_range(99) < 85) begin
      if (row.op == oale_pkg::OP_INSERT) row.pos = 5'($urandom_range(list_cnt));
      else if (list_cnt > 0) row.pos = 5'($urandom_range(list_cnt - 1));
    end
    row.key = {$urandom, $urandom};
    if ($urandom_range(99) < 30) row.key = 64'($urandom_range(3));
    if (row.op == oale_pkg::OP_FIND && list_cnt > 0 && $urandom_range(99) < 70)
      row.key = key_mem[$urandom_range(list_cnt - 1)];
    row.pay = $urandom;
    row.typed = 1'b0;
    row.res = '{st: oale_pkg::STAT_OK, fpos: '0, key: '0, pay: '0, cnt: '0};
    return row;
  endfunction

  // result side: random stall, compare against the oldest expectation
  always @(posedge clk) begin
    rsp_stall <= !rst && ($urandom_range(99) < rcv_idle);
    if (!rst && rsp_valid && !rsp_stall) begin
      n_results++;
      if (expected_results.size() == 0) begin
        $error("result with no item outstanding: status %0d count %0d", status, entry_count);
        errors++;
      end else begin
        head = expected_results.pop_front();
        if (status !== head.st) begin
          $error("status: expected %0d, got %0d", head.st, status);
          errors++;
        end
        if (found_position !== head.fpos) begin
          $error("found_position: expected %0d, got %0d", head.fpos, found_position);
          errors++;
        end
        if (read_key !== head.key) begin
          $error("read_key: expected %h, got %h", head.key, read_key);
          errors++;
        end
        if (read_payload !== head.pay) begin
          $error("read_payload: expected %h, got %h", head.pay, read_payload);
          errors++;
        end
        if (entry_count !== head.cnt) begin
          $error("entry_count: expected %0d, got %0d", head.cnt, entry_count);
          errors++;
        end
        case (head.st)
          oale_pkg::STAT_FULL: n_full++;
          oale_pkg::STAT_RANGE: n_range++;
          oale_pkg::STAT_NOKEY: n_nokey++;
          default: ;
        endcase
        if (int'(head.cnt) > peak_cnt) peak_cnt = int'(head.cnt);
      end
    end
  end

  // watchdog on handshake activity
  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("timeout: no handshake in %0d cycles", STALL_LIMIT);
        $display("FAILURE");
        $finish;
      end
    end
  end

  initial begin
    list_row_t row;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // empty list: every position out of range, nothing to find
    add_row(oale_pkg::OP_READ,   0, 5'd0,  '0, '0, 1, oale_pkg::STAT_RANGE);
    add_row(oale_pkg::OP_DELETE, 0, 5'd31, '0, '0, 1, oale_pkg::STAT_RANGE);
    add_row(oale_pkg::OP_WRITE,  0, 5'd31, '1, '1, 1, oale_pkg::STAT_RANGE);
    add_row(oale_pkg::OP_FIND,   0, 5'd0,  '1, '0, 1, oale_pkg::STAT_NOKEY);
    add_row(oale_pkg::OP_INSERT, 0, 5'd1,  '1, '1, 1, oale_pkg::STAT_RANGE);
    add_row(oale_pkg::OP_INSERT, 0, 5'd0,  '1, '1, 1, oale_pkg::STAT_OK, 5'd0, '0, '0, 6'd1);
    add_row(oale_pkg::OP_READ,   0, 5'd0,  '0, '0, 1, oale_pkg::STAT_OK, 5'd0, '1, '1, 6'd1);
    // append ignores position
    add_row(oale_pkg::OP_INSERT, 1, 5'd31, '0, '0, 1, oale_pkg::STAT_OK, 5'd0, '0, '0, 6'd2);
    add_row(oale_pkg::OP_FIND,   0, 5'd0,  '0, '1, 1, oale_pkg::STAT_OK, 5'd1, '0, '0, 6'd2);
    add_row(oale_pkg::OP_WRITE,  0, 5'd1,  64'h5555_5555_5555_5555, 32'hAAAA_AAAA, 1,
            oale_pkg::STAT_OK, 5'd0, '0, '0, 6'd2);
    add_row(oale_pkg::OP_READ,   0, 5'd2,  '0, '0, 1, oale_pkg::STAT_RANGE, 5'd0, '0, '0, 6'd2);
    add_row(OP_SPARE_A,          0, 5'd0,  '0, '0, 1, oale_pkg::STAT_OK, 5'd0, '0, '0, 6'd2);
    add_row(OP_SPARE_B,          1, 5'd31, '1, '1, 1, oale_pkg::STAT_OK, 5'd0, '0, '0, 6'd2);
    add_row(oale_pkg::OP_INSERT, 0, 5'd1,  64'h0123_4567_89AB_CDEF, 32'h89AB_CDEF, 0);
    add_row(oale_pkg::OP_INSERT, 0, 5'd3,  64'hAAAA_AAAA_AAAA_AAAA, 32'h5555_5555, 0);
    add_row(oale_pkg::OP_FIND,   0, 5'd0,  64'h5555_5555_5555_5555, '0, 0);
    add_row(oale_pkg::OP_DELETE, 0, 5'd0,  '0, '0, 0);
    add_row(oale_pkg::OP_READ,   0, 5'd2,  '0, '0, 0);
    add_row(oale_pkg::OP_DELETE, 0, 5'd2,  '0, '0, 0);
    add_row(oale_pkg::OP_FIND,   0, 5'd0,  '0, '0, 0);
    add_row(oale_pkg::OP_CLEAR,  0, 5'd0,  '0, '0, 1, oale_pkg::STAT_OK, 5'd0, '0, '0, 6'd0);
    add_row(oale_pkg::OP_READ,   0, 5'd0,  '0, '0, 1, oale_pkg::STAT_RANGE, 5'd0, '0, '0, 6'd0);

    foreach (dir_rows[i]) send_item(dir_rows[i]);

    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (n == PHASE_LEN) begin
        drain_pause();
        snd_idle = 61;
        rcv_idle = 36;
      end else if (n == 2 * PHASE_LEN) begin
        drain_pause();
        snd_idle = 0;
        rcv_idle = 0;
      end
      row = random_row(n);
      send_item(row);
    end

    drain_pause();
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("Ran %0d items (%0d results), list filled to at most %0d entries.",
             n_items, n_results, peak_cnt);
    $display("Full-list rejects %0d, out-of-range positions %0d, failed finds %0d.",
             n_full, n_range, n_nokey);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/oale_pkg.sv
rtl/oale_ram.sv
rtl/ordered_array_list_engine_core.sv
verif/ordered_array_list_engine_core_tb.sv
